// ===== design/bgcd_pkg.sv =====
package bgcd_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int COUNT_WIDTH_DEF = 40;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic done;
    } t_status;

endpackage

// ===== design/bgcd_ctrl.sv =====
module bgcd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  bgcd_pkg::t_status i_status,
    output bgcd_pkg::t_cmd  o_cmd
);
    import bgcd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (!i_status.done) begin
                    o_cmd.step = 1'b1;
                end else if (slot_free) begin
                    // result goes into the output register, tally updates
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== design/bgcd_datapath.sv =====
module bgcd_datapath #(
    parameter int VALUE_WIDTH = bgcd_pkg::VALUE_WIDTH_DEF,
    parameter int COUNT_WIDTH = bgcd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bgcd_pkg::t_cmd         i_cmd,
    input  logic [VALUE_WIDTH-1:0] i_first_value,
    input  logic [VALUE_WIDTH-1:0] i_second_value,
    output bgcd_pkg::t_status      o_status,
    output logic                   o_is_coprime,
    output logic [COUNT_WIDTH-1:0] o_coprime_total
);
    import bgcd_pkg::*;

    localparam logic [VALUE_WIDTH-1:0] ONE_V = VALUE_WIDTH'(1);
    localparam logic [VALUE_WIDTH-1:0] ZERO_V = '0;

    logic [VALUE_WIDTH-1:0] r_a, n_a;
    logic [VALUE_WIDTH-1:0] r_b, n_b;
    logic                   r_special, n_special;
    logic                   r_special_hit, n_special_hit;
    logic                   r_is_coprime;
    logic [COUNT_WIDTH-1:0] r_tally, n_tally;
    logic                   a_gt_b;
    logic [VALUE_WIDTH-1:0] diff;
    logic                   zero_case;
    logic                   hit;

    assign a_gt_b = r_a > r_b;
    assign diff   = a_gt_b ? (r_a - r_b) : (r_b - r_a);

    assign zero_case = (i_first_value == ZERO_V) || (i_second_value == ZERO_V);

    always_comb begin
        n_a           = r_a;
        n_b           = r_b;
        n_special     = r_special;
        n_special_hit = r_special_hit;
        if (i_cmd.load) begin
            n_a = i_first_value;
            n_b = i_second_value;
            // a zero operand or a shared factor of two settles it at once
            n_special     = zero_case || (!i_first_value[0] && !i_second_value[0]);
            n_special_hit = ((i_first_value == ZERO_V) && (i_second_value == ONE_V))
                         || ((i_second_value == ZERO_V) && (i_first_value == ONE_V));
        end else if (i_cmd.step) begin
            if (!r_a[0]) begin
                n_a = r_a >> 1;
            end else if (!r_b[0]) begin
                n_b = r_b >> 1;
            end else if (a_gt_b) begin
                n_a = diff >> 1;
            end else begin
                n_b = diff >> 1;
            end
        end
    end

    assign hit = r_special ? r_special_hit : (r_a == ONE_V);

    always_comb begin
        n_tally = r_tally;
        if (i_cmd.finish && hit && (r_tally != '1)) begin
            n_tally = r_tally + COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_a           <= n_a;
        r_b           <= n_b;
        r_special     <= n_special;
        r_special_hit <= n_special_hit;
        if (i_cmd.finish) begin
            r_is_coprime <= hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally <= '0;
        end else begin
            r_tally <= n_tally;
        end
    end

    // odd parts meet at their gcd
    assign o_status.done   = r_special || (r_a == r_b);
    assign o_is_coprime    = r_is_coprime;
    assign o_coprime_total = r_tally;

endmodule

// ===== design/binary_gcd_coprime_counter.sv =====
// binary gcd coprime counter
// input channel: i_in_valid / o_in_ready carry a pair i_first_value, i_second_value;
// a beat is taken at a rising edge with both valid and ready high.
// output channel: o_out_valid / i_out_ready carry o_is_coprime (gcd equals one)
// and o_coprime_total, the saturating count of coprime pairs including this one.
// one output beat for every input beat, in order.
// the pair loads at its accepting edge, then the datapath runs its reduction rounds
// and posts the result; a round either halves an even operand or replaces the
// larger odd operand by half the difference, so an item needs 0 to 2*VALUE_WIDTH-2
// rounds, set by the single subtract-and-shift unit. a zero operand or two even
// operands need no rounds.
// one pair is worked on at a time; o_in_ready is high while the datapath is free.
// the result sits in an output register, so a new pair is taken while the last
// result waits; if the receiver stalls, a finished pair holds until the slot frees.
// reset clears the count, the output valid and returns the controller to idle.
module binary_gcd_coprime_counter #(
    parameter int VALUE_WIDTH = bgcd_pkg::VALUE_WIDTH_DEF,
    parameter int COUNT_WIDTH = bgcd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [VALUE_WIDTH-1:0] i_first_value,
    input  logic [VALUE_WIDTH-1:0] i_second_value,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_is_coprime,
    output logic [COUNT_WIDTH-1:0] o_coprime_total
);
    import bgcd_pkg::*;

    t_cmd    cmd;
    t_status status;

    bgcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    bgcd_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_first_value   (i_first_value),
        .i_second_value  (i_second_value),
        .o_status        (status),
        .o_is_coprime    (o_is_coprime),
        .o_coprime_total (o_coprime_total)
    );

`ifndef SYNTHESIS
    // the count moves only by one, and only with a coprime result
    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_coprime_total != $past(o_coprime_total)) |->
        ((o_coprime_total == $past(o_coprime_total) + COUNT_WIDTH'(1)) && o_is_coprime))
        else $error("coprime total changed without a coprime result");

    // a taken pair leaves the datapath busy in the cycle after it is taken
    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after a beat was taken");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_coprime) |-> (o_coprime_total != '0))
        else $error("coprime result with a zero total");
`endif

endmodule

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW          = bgcd_pkg::VALUE_WIDTH_DEF;
    localparam int CW          = bgcd_pkg::COUNT_WIDTH_DEF;
    localparam int PHASE_PAIRS = 300;
    localparam int HOLD_CYCLES = 400;
    // bound on the run, with room for worst-case pairs plus random gaps and stalls
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic [VW-1:0] first_value;
        logic [VW-1:0] second_value;
    } t_pair;

    typedef struct packed {
        logic          is_coprime;
        logic [CW-1:0] coprime_total;
    } t_verdict;

    logic          i_clk           = 1'b0;
    logic          i_rst_n         = 1'b0;
    logic          pair_valid      = 1'b0;
    logic [VW-1:0] first_value     = '0;
    logic [VW-1:0] second_value    = '0;
    logic          verdict_ready   = 1'b0;
    logic          o_in_ready;
    logic          o_out_valid;
    logic          o_is_coprime;
    logic [CW-1:0] o_coprime_total;

    t_pair    pair_queue[$];
    t_verdict verdict_queue[$];
    bit [CW-1:0] coprime_count = '0;
    bit  pair_taken     = 1'b0;
    int  send_idle_pct  = 0;
    int  stall_pct      = 0;
    int  hold_requests  = 0;
    int  hold_served    = 0;
    int  hold_left      = 0;
    int  cycle_count    = 0;
    int  mismatch_count = 0;

    binary_gcd_coprime_counter i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (pair_valid),
        .o_in_ready     (o_in_ready),
        .i_first_value  (first_value),
        .i_second_value (second_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (verdict_ready),
        .o_is_coprime   (o_is_coprime),
        .o_coprime_total(o_coprime_total)
    );

    always #2 i_clk = ~i_clk;

    // euclid by remainder; gcd(0, x) = x so a zero operand needs no special path
    function automatic bit gcd_is_one(bit [VW-1:0] a, bit [VW-1:0] b);
        bit [VW-1:0] r;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a == 1;
    endfunction

    function automatic bit [VW-1:0] random_operand();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom;
            4:          return $urandom_range(0, 20);
            5:          return $urandom | 1;
            6:          return $urandom << $urandom_range(0, VW - 1);
            7:          return 1 << $urandom_range(0, VW - 1);
            default: begin
                case ($urandom_range(3))
                    0:       return '0;
                    1:       return 1;
                    2:       return '1;
                    default: return $urandom_range(0, 65535);
                endcase
            end
        endcase
    endfunction

    task automatic add_pair(bit [VW-1:0] a, bit [VW-1:0] b);
        t_pair p;
        p.first_value  = a;
        p.second_value = b;
        pair_queue.push_back(p);
    endtask

    task automatic note_mismatch(string msg);
        if (mismatch_count < 10)
            $display("%0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic wait_drained();
        while (pair_queue.size() != 0 || pair_valid || verdict_queue.size() != 0
               || hold_left != 0)
            @(negedge i_clk);
    endtask

    // driver: new beat only once the current one is taken
    always @(negedge i_clk) begin
        t_pair p;
        if (!i_rst_n) begin
            pair_valid <= 1'b0;
        end else if (!pair_valid || pair_taken) begin
            if (pair_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                p = pair_queue.pop_front();
                pair_valid   <= 1'b1;
                first_value  <= p.first_value;
                second_value <= p.second_value;
            end else begin
                pair_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || hold_left != 0)
            verdict_ready <= 1'b0;
        else
            verdict_ready <= ($urandom_range(99) >= stall_pct);
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: predicts on each input beat, checks each output beat
    always @(posedge i_clk) begin
        t_verdict v;
        cycle_count++;
        pair_taken = 1'b0;
        if (i_rst_n) begin
            if (pair_valid && o_in_ready) begin
                pair_taken   = 1'b1;
                v.is_coprime = gcd_is_one(first_value, second_value);
                if (v.is_coprime && coprime_count != '1)
                    coprime_count++;
                v.coprime_total = coprime_count;
                verdict_queue.push_back(v);
            end
            if (o_out_valid && verdict_ready) begin
                if (verdict_queue.size() == 0) begin
                    note_mismatch($sformatf("unexpected beat: is_coprime=%0b total=%0d",
                                            o_is_coprime, o_coprime_total));
                end else begin
                    v = verdict_queue.pop_front();
                    if (o_is_coprime !== v.is_coprime)
                        note_mismatch($sformatf("is_coprime: expected %0b, got %0b",
                                                v.is_coprime, o_is_coprime));
                    if (o_coprime_total !== v.coprime_total)
                        note_mismatch($sformatf("coprime_total: expected %0d, got %0d",
                                                v.coprime_total, o_coprime_total));
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int send_mix[4];
        int stall_mix[4];
        send_mix  = '{0, 46, 0, 22};
        stall_mix = '{0, 0, 46, 22};

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero operands, ones, extremes, powers of two, equal and long-running pairs
        add_pair(0, 0);
        add_pair(0, 1);
        add_pair(1, 0);
        add_pair(0, 5);
        add_pair(7, 0);
        add_pair('1, 0);
        add_pair(1, 1);
        add_pair('1, '1);
        add_pair('1, 1);
        add_pair(1, '1);
        add_pair('1, '1 - 1);
        add_pair(32'h8000_0000, 32'h8000_0000);
        add_pair(32'h8000_0000, 1);
        add_pair(32'h8000_0000, 3);
        add_pair(6, 4);
        add_pair(12, 18);
        add_pair(17, 34);
        add_pair(3, 5);
        add_pair(9, 9);
        add_pair(2, 2);
        add_pair(32'h8000_0001, 32'h7FFF_FFFF);
        add_pair(32'hFFFF_FFFE, 32'h7FFF_FFFF);
        add_pair(1836311903, 1134903170);
        add_pair(32'h5555_5555, 32'hAAAA_AAAA);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = send_mix[ph];
            stall_pct     = stall_mix[ph];
            for (int k = 0; k < PHASE_PAIRS; k++) begin
                if ($urandom_range(15) == 0)
                    add_pair(random_operand(), 0) ;
                else
                    add_pair(random_operand(), random_operand());
            end
            wait_drained();
        end

        // receiver blocked while the sender keeps offering
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_requests++;
        for (int k = 0; k < 20; k++)
            add_pair($urandom, $urandom);
        @(negedge i_clk);
        wait_drained();

        repeat (2 * VW + 8) @(posedge i_clk);
        if (verdict_queue.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", verdict_queue.size()));
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
